// ===== rtl/core/fqs_pkg.sv =====
// ============================================================================
// fqs_pkg
// Shared widths, register indexes and control types for the saturating
// Q15 FIR filter and its multiply-accumulate unit.
// ============================================================================
package fqs_pkg;

    // Sample and coefficient width (Q15)
    localparam int SAMPLE_W   = 16;
    // Full product of two Q15 values
    localparam int PROD_W     = 2 * SAMPLE_W;
    // Maximum tap count and derived widths
    localparam int MAX_TAPS   = 24;
    localparam int TAP_W      = 5;
    // Accumulator: product plus headroom for 24 terms and rounding
    localparam int ACC_W      = PROD_W + 6;
    // Configuration port
    localparam int COEF_PACKS = 6;
    localparam int PACK_W     = 64;
    localparam int PACK_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SCALE_W    = 4;
    localparam int GROUPS_W   = 2;
    localparam int SHIFT_W    = 4;

    // Largest usable scale
    localparam logic [SCALE_W-1:0] SCALE_MAX = 4'd14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_GROUPS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_5     = 3'd7;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;    // zero the accumulator and drop any product in flight
        logic issue;    // multiply the current operands this cycle
    } mac_ctrl_t;

endpackage

// ===== rtl/core/fir_filter_q15_saturating.sv =====
// ============================================================================
// fir_filter_q15_saturating
// Q15 FIR filter with 8, 16 or 24 taps, rounding, gain shift and saturation.
// One sample beat in gives one filtered sample beat out. The block computes
// the taps one after another on a single 16x16 multiplier; taps is 8 times
// tap_groups, and zero groups gives a zero result. The input is ready again
// once the result is registered on the output, so a new sample is taken only
// after the last one is through. A result waiting on the output does not stop
// the next input beat, but a finished result that finds the output still full
// holds the filter, and its input, until that beat is taken. coef 0 weighs
// the oldest sample of the window. Configuration is to be written through the
// cfg channel only while the filter is idle; the block does not enforce this.
// ============================================================================
module fir_filter_q15_saturating
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fqs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fqs_pkg::PACK_W-1:0]           cfg_data,

    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fqs_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample

    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fqs_pkg::SAMPLE_W-1:0]         m_axis_tdata    // [15:0] filtered
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic signed [fqs_pkg::SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [fqs_pkg::SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

    // Configuration registers
    logic [fqs_pkg::SCALE_W-1:0]  scale_reg;
    logic [fqs_pkg::GROUPS_W-1:0] tap_groups_reg;
    logic [fqs_pkg::PACK_W-1:0]   coef_pack_reg [fqs_pkg::COEF_PACKS];

    // Sample window, index 0 newest
    logic signed [fqs_pkg::SAMPLE_W-1:0] win_reg [fqs_pkg::MAX_TAPS];

    // Sequencer
    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [fqs_pkg::TAP_W-1:0]    m_reg;
    logic [fqs_pkg::TAP_W-1:0]    m_next;
    logic [fqs_pkg::TAP_W-1:0]    taps_reg;
    logic [fqs_pkg::TAP_W-1:0]    taps_now;
    logic [fqs_pkg::SHIFT_W-1:0]  shift_reg;
    logic [fqs_pkg::SCALE_W-1:0]  scale_eff;

    // Output register
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [fqs_pkg::SAMPLE_W-1:0] out_data_reg;

    logic                                in_beat;
    logic                                out_beat;
    logic                                out_load;
    fqs_pkg::mac_ctrl_t                  mac_ctrl;
    logic [fqs_pkg::TAP_W-1:0]           age;
    logic [fqs_pkg::PACK_IDX_W-1:0]      pack_sel;
    logic [fqs_pkg::PACK_W-1:0]          pack_word;
    logic signed [fqs_pkg::SAMPLE_W-1:0] x_op;
    logic signed [fqs_pkg::SAMPLE_W-1:0] c_op;
    logic signed [fqs_pkg::ACC_W-1:0]    acc;
    logic signed [fqs_pkg::ACC_W-1:0]    rounded;
    logic signed [fqs_pkg::ACC_W-1:0]    shifted;
    logic signed [fqs_pkg::SAMPLE_W-1:0] sat_val;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;
    assign out_load      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    // Tap count and effective scale at the start of an item
    assign taps_now  = {tap_groups_reg, 3'b000};
    assign scale_eff = (scale_reg > fqs_pkg::SCALE_MAX) ? fqs_pkg::SCALE_MAX : scale_reg;

    // Select the operands for tap m
    assign age       = taps_reg - fqs_pkg::TAP_W'(1) - m_reg;
    assign x_op      = win_reg[age];
    assign pack_sel  = m_reg[fqs_pkg::TAP_W-1:2];
    assign pack_word = coef_pack_reg[pack_sel];
    assign c_op      = pack_word[m_reg[1:0]*fqs_pkg::SAMPLE_W +: fqs_pkg::SAMPLE_W];

    // Drive the shared unit
    always_comb
    begin
        mac_ctrl.clear = in_beat;
        mac_ctrl.issue = (state_reg == ST_MAC);
    end

    fqs_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .x     (x_op),
        .c     (c_op),
        .acc   (acc)
    );

    // Round, shift down and saturate the finished sum
    always_comb
    begin
        rounded = acc + (fqs_pkg::ACC_W'(1) << (shift_reg - fqs_pkg::SHIFT_W'(1)));
        shifted = rounded >>> shift_reg;
        if (shifted > fqs_pkg::ACC_W'(SAT_MAX))
        begin
            sat_val = SAT_MAX;
        end
        else if (shifted < fqs_pkg::ACC_W'(SAT_MIN))
        begin
            sat_val = SAT_MIN;
        end
        else
        begin
            sat_val = shifted[fqs_pkg::SAMPLE_W-1:0];
        end
    end

    // Step through the taps
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                m_next = '0;
                if (in_beat)
                begin
                    state_next = (taps_now == '0) ? ST_DRAIN : ST_MAC;
                end
            end
            ST_MAC:
            begin
                m_next = m_reg + fqs_pkg::TAP_W'(1);
                if (m_reg == taps_reg - fqs_pkg::TAP_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_beat)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_reg         <= '0;
            taps_reg      <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            out_valid_reg <= out_valid_next;
            if (in_beat)
            begin
                taps_reg  <= taps_now;
                shift_reg <= fqs_pkg::SHIFT_W'(15) - fqs_pkg::SHIFT_W'(scale_eff);
            end
        end
    end

    // Hold the result for the output side
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= sat_val;
        end
    end

    // Shift the new sample into the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fqs_pkg::MAX_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (in_beat)
        begin
            win_reg[0] <= s_axis_tdata;
            for (int k = 1; k < fqs_pkg::MAX_TAPS; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= '0;
            tap_groups_reg <= fqs_pkg::GROUPS_W'(1);
            for (int k = 0; k < fqs_pkg::COEF_PACKS; k++)
            begin
                coef_pack_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fqs_pkg::REG_SCALE:      scale_reg      <= cfg_data[fqs_pkg::SCALE_W-1:0];
                fqs_pkg::REG_TAP_GROUPS: tap_groups_reg <= cfg_data[fqs_pkg::GROUPS_W-1:0];
                fqs_pkg::REG_COEF_0:     coef_pack_reg[0] <= cfg_data;
                fqs_pkg::REG_COEF_1:     coef_pack_reg[1] <= cfg_data;
                fqs_pkg::REG_COEF_2:     coef_pack_reg[2] <= cfg_data;
                fqs_pkg::REG_COEF_3:     coef_pack_reg[3] <= cfg_data;
                fqs_pkg::REG_COEF_4:     coef_pack_reg[4] <= cfg_data;
                fqs_pkg::REG_COEF_5:     coef_pack_reg[5] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Tap counter stays inside the active tap range while multiplying
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (m_reg < taps_reg))
        else $error("tap counter ran past the tap count");

    // An accepted sample starts the tap sweep, or drains at once with no taps
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> ((state_reg == ST_MAC) || (state_reg == ST_DRAIN)))
        else $error("accepted sample did not start the sequencer");

    // A finished result waits while the output register is still full
    a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && out_valid_reg && !m_axis_tready) |=> (state_reg == ST_FIN))
        else $error("result overwrote an untaken output beat");

    // A new output beat appears only after the finish step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("output valid raised outside the finish step");

endmodule

// ===== rtl/core/fqs_mac.sv =====
// ============================================================================
// fqs_mac
// Shared signed 16x16 multiplier with a registered product, followed by an
// exact wide accumulator. One product per cycle while ctrl.issue is high.
// ============================================================================
module fqs_mac
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fqs_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [fqs_pkg::SAMPLE_W-1:0] x,
    input  logic signed [fqs_pkg::SAMPLE_W-1:0] c,
    output logic signed [fqs_pkg::ACC_W-1:0]    acc
);

    logic signed [fqs_pkg::PROD_W-1:0] prod_reg;
    logic signed [fqs_pkg::PROD_W-1:0] prod_next;
    logic                              prod_valid_reg;
    logic signed [fqs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fqs_pkg::ACC_W-1:0]  acc_next;

    // Multiply the operands
    assign prod_next = x * c;

    // Add the registered product into the running sum
    always_comb
    begin
        acc_next = acc_reg;
        if (prod_valid_reg)
        begin
            acc_next = acc_reg + fqs_pkg::ACC_W'(prod_reg);
        end
    end

    // Hold the product between the multiplier and the adder
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= prod_next;
        end
    end

    // Advance the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else if (ctrl.clear)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
            acc_reg        <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
